/* sv/mrqs_pkg.sv */
// Shared types and constants for the ready-queue scheduler.
package mrqs_pkg;
   localparam int MaxProcs = 16;
   localparam int Levels   = 4;
   localparam int PidW     = $clog2(MaxProcs);
   localparam int LvW      = $clog2(Levels);

   localparam logic [2:0] REQ_YIELD = 3'd0;
   localparam logic [2:0] REQ_BLOCK = 3'd1;
   localparam logic [2:0] REQ_WAKE  = 3'd2;
   localparam logic [2:0] REQ_SETP  = 3'd3;
   localparam logic [2:0] REQ_GETP  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BADPRIO = 2'd1;
   localparam logic [1:0] ST_QUEUED  = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   localparam logic [LvW-1:0] MaxUsable = LvW'(Levels - 2);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_RDA   = 8'b0000_0010,
      S_ENQ   = 8'b0000_0100,
      S_DEQR  = 8'b0000_1000,
      S_DEQ   = 8'b0001_0000,
      S_WALK  = 8'b0010_0000,
      S_WALKR = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;
endpackage

/* sv/multilevel_ready_queue_scheduler_top.sv */
// Top level of the multilevel ready-queue scheduler.
// A request is latched, then served by one memory read of the slot pool per
// list step, and its result is presented in S_OUT. Get priority, a rejected
// request and an ignored kind go straight to the result; wake enqueues, block
// dequeues, and yield with a requeue of the running process enqueues it and
// then dequeues. The set-priority unlink walks the level's list slot by
// slot, alternating S_WALKR and S_WALK for each slot it visits.
// Slot links live in a one-read-port synchronous memory; priorities, heads
// and tails sit in flip-flops. Free slot = slot of the same index as the
// process, since each process is queued at most once. The result register
// frees the next request only after the result has been taken.
module multilevel_ready_queue_scheduler_top
   import mrqs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [2:0]      req_req_type,
   input  logic [3:0]      req_proc_id,
   input  logic [1:0]      req_new_priority,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [3:0]      rsp_next_proc,
   output logic            rsp_next_valid,
   output logic [1:0]      rsp_priority_out
);
   // Slot s is owned by process s; queued bit doubles as slot occupancy.
   logic [PidW-1:0] link_mem [MaxProcs];
   logic [PidW-1:0] link_rd_ff;
   logic            link_we;
   logic [PidW-1:0] link_wa, link_wd, link_ra;

   logic [LvW-1:0]  prio_ff [MaxProcs];
   logic [MaxProcs-1:0] queued_ff;
   logic [Levels-1:0]   hvalid_ff;
   logic [PidW-1:0] head_ff [Levels];
   logic [PidW-1:0] tail_ff [Levels];
   logic            run_v_ff;
   logic [PidW-1:0] run_ff;

   state_type       state_ff;
   logic [2:0]      rt_ff;
   logic [PidW-1:0] pid_ff;
   logic [LvW-1:0]  np_ff;
   logic [PidW-1:0] cur_ff, prev_ff;
   logic            prev_v_ff;
   logic [PidW-1:0] epid_ff;
   logic [LvW-1:0]  elv_ff;
   logic            after_deq_ff;

   logic [1:0]      st_ff;
   logic [PidW-1:0] nx_ff;
   logic            nv_ff;
   logic [1:0]      po_ff;

   // yield puts the running process back first unless it is already queued
   logic            requeue_run;
   assign requeue_run = (rt_ff == REQ_YIELD) && run_v_ff && !queued_ff[run_ff];

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
      link_rd_ff <= link_mem[link_ra];
   end

   // lowest-numbered non-empty level
   logic            any_ready;
   logic [LvW-1:0]  best_lv;
   always_comb begin
      any_ready = 1'b0;
      best_lv   = '0;
      for (int i = Levels - 1; i >= 0; i--) begin
         if (hvalid_ff[i]) begin
            any_ready = 1'b1;
            best_lv   = LvW'(i);
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_status = st_ff;
   assign rsp_next_proc = nx_ff;
   assign rsp_next_valid = nv_ff;
   assign rsp_priority_out = po_ff;

   logic [PidW-1:0] bhead;
   assign bhead = head_ff[best_lv];

   always_comb begin
      link_we = 1'b0;
      link_wa = epid_ff;
      link_wd = epid_ff;
      link_ra = cur_ff;
      case (state_ff)
         S_ENQ: begin
            if (hvalid_ff[elv_ff]) begin
               link_we = 1'b1;
               link_wa = tail_ff[elv_ff];
            end
         end
         S_DEQR: link_ra = bhead;
         S_WALK: begin
            link_ra = cur_ff;
            if (cur_ff == pid_ff && prev_v_ff) begin
               link_we = 1'b1;
               link_wa = prev_ff;
               link_wd = link_rd_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         queued_ff <= '0;
         hvalid_ff <= '0;
         run_v_ff  <= 1'b0;
         for (int i = 0; i < MaxProcs; i++) prio_ff[i] <= MaxUsable;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  rt_ff <= req_req_type;
                  pid_ff <= req_proc_id;
                  np_ff <= req_new_priority;
                  st_ff <= ST_OK;
                  nx_ff <= '0;
                  nv_ff <= 1'b0;
                  po_ff <= '0;
                  state_ff <= S_RDA;
               end
            end
            S_RDA: begin
               after_deq_ff <= requeue_run;
               case (rt_ff)
                  REQ_YIELD, REQ_BLOCK: begin
                     if (requeue_run) begin
                        epid_ff <= run_ff;
                        elv_ff <= prio_ff[run_ff];
                        state_ff <= S_ENQ;
                     end else state_ff <= S_DEQR;
                  end
                  REQ_WAKE: begin
                     if (queued_ff[pid_ff]) begin
                        st_ff <= ST_QUEUED;
                        state_ff <= S_OUT;
                     end else begin
                        epid_ff <= pid_ff;
                        elv_ff <= prio_ff[pid_ff];
                        state_ff <= S_ENQ;
                     end
                  end
                  REQ_SETP: begin
                     if (32'(np_ff) + 2 > Levels) begin
                        st_ff <= ST_BADPRIO;
                        state_ff <= S_OUT;
                     end else if (np_ff != prio_ff[pid_ff] && queued_ff[pid_ff]) begin
                        cur_ff <= head_ff[prio_ff[pid_ff]];
                        prev_v_ff <= 1'b0;
                        elv_ff <= prio_ff[pid_ff];
                        state_ff <= S_WALKR;
                     end else begin
                        prio_ff[pid_ff] <= np_ff;
                        state_ff <= S_OUT;
                     end
                  end
                  REQ_GETP: begin
                     po_ff <= prio_ff[pid_ff];
                     state_ff <= S_OUT;
                  end
                  default: state_ff <= S_OUT;
               endcase
            end
            S_ENQ: begin
               if (!hvalid_ff[elv_ff]) begin
                  hvalid_ff[elv_ff] <= 1'b1;
                  head_ff[elv_ff] <= epid_ff;
               end
               tail_ff[elv_ff] <= epid_ff;
               queued_ff[epid_ff] <= 1'b1;
               state_ff <= after_deq_ff ? S_DEQR : S_OUT;
            end
            S_DEQR: state_ff <= S_DEQ;
            S_DEQ: begin
               if (any_ready) begin
                  queued_ff[bhead] <= 1'b0;
                  if (bhead == tail_ff[best_lv]) hvalid_ff[best_lv] <= 1'b0;
                  else head_ff[best_lv] <= link_rd_ff;
                  run_ff <= bhead;
                  run_v_ff <= 1'b1;
                  nx_ff <= bhead;
                  nv_ff <= 1'b1;
               end else begin
                  run_v_ff <= 1'b0;
                  st_ff <= ST_EMPTY;
               end
               state_ff <= S_OUT;
            end
            S_WALKR: state_ff <= S_WALK;
            S_WALK: begin
               // link_rd_ff holds link of cur_ff
               if (cur_ff == pid_ff) begin
                  if (!prev_v_ff) begin
                     if (cur_ff == tail_ff[elv_ff]) hvalid_ff[elv_ff] <= 1'b0;
                     else head_ff[elv_ff] <= link_rd_ff;
                  end else if (cur_ff == tail_ff[elv_ff]) tail_ff[elv_ff] <= prev_ff;
                  queued_ff[pid_ff] <= 1'b0;
                  prio_ff[pid_ff] <= np_ff;
                  epid_ff <= pid_ff;
                  elv_ff <= np_ff;
                  state_ff <= S_ENQ;
               end else begin
                  prev_ff <= cur_ff;
                  prev_v_ff <= 1'b1;
                  cur_ff <= link_rd_ff;
                  state_ff <= S_WALKR;
               end
            end
            S_OUT: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped");
   a_nv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_next_valid |-> rsp_status == ST_OK)
      else $error("bad status with selection");
endmodule
